// File: rtl/afgr_pkg.sv
// shared constants, word types and controller interface for the audio output fifo
`timescale 1ns / 1ps
`default_nettype none
package afgr_pkg;

	// ring geometry
	localparam int RING_DEPTH = 1024;
	localparam int MAX_BLOCK  = 64;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int CAP_W      = 11;
	localparam int CNT_W      = 40;
	localparam int FRAME_W    = 32;
	localparam int BLK_W      = 7;

	// gain arithmetic
	localparam int GAIN_W     = 18;
	localparam int GAIN_MAX   = 131072;
	localparam int GNUM_W     = 26;
	localparam int DELTA_W    = 19;
	localparam int PROD_W     = 39;
	localparam int QUOT_W     = 23;

	// serial divider
	localparam int DIV_W      = 40;
	localparam int DIVR_W     = 11;
	localparam int STEP_W     = 6;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;

	// operation codes
	localparam logic [2:0] OP_WRITE  = 3'd0;
	localparam logic [2:0] OP_PULL   = 3'd1;
	localparam logic [2:0] OP_FLUSH  = 3'd2;
	localparam logic [2:0] OP_EOS    = 3'd3;
	localparam logic [2:0] OP_PLAY   = 3'd4;
	localparam logic [2:0] OP_VOLUME = 3'd5;

	typedef struct packed {
		logic [2:0]          op;
		logic signed [15:0]  left_sample;
		logic signed [15:0]  right_sample;
		logic [6:0]          block_frames;
		logic                play_flag;
		logic [17:0]         volume;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0]  left_out;
		logic signed [15:0]  right_out;
		logic                from_ring;
		logic                accepted;
		logic                last;
		logic [31:0]         underrun_total;
		logic [10:0]         fill_level;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RC_START,
		ST_RC_WAIT,
		ST_EXEC,
		ST_FRAME,
		ST_FR_MUL,
		ST_FR_DIV_START,
		ST_FR_DIV_WAIT,
		ST_FR_EMIT
	} state_t;

	typedef struct packed {
		logic cfg_take;
		logic item_take;
		logic rc_start;
		logic rc_finish;
		logic pull_setup;
		logic simple_exec;
		logic fr_read;
		logic fr_mul;
		logic fr_div_start;
		logic fr_emit;
		logic zero_emit;
	} dp_cmd_t;

	typedef struct packed {
		logic       is_pull;
		logic       pull_zero;
		logic       k_lt_avail;
		logic       last_frame;
		logic       div_done;
		logic       out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/afgr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module afgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: rtl/afgr_div.sv
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module afgr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [afgr_pkg::DIV_W-1:0]  dividend,
	input  logic [afgr_pkg::DIVR_W-1:0] divisor,
	input  logic [afgr_pkg::STEP_W-1:0] steps,
	output logic                       done,
	output logic [afgr_pkg::DIV_W-1:0]  quotient,
	output logic [afgr_pkg::DIVR_W-1:0] remainder
);
	import afgr_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [DIV_W-1:0]    dvd_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DIVR_W-1:0]   rem_q;
	logic [DIVR_W-1:0]   dvs_q;
	logic [DIVR_W:0]     trial;
	logic                qbit;
	logic [DIVR_W:0]     diff;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = trial >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// File: rtl/afgr_dp.sv
// datapath: ring, counters, gain ramp arithmetic and output register
`timescale 1ns / 1ps
`default_nettype none
module afgr_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  afgr_pkg::in_word_t              in_data,
	input  logic [afgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [afgr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  afgr_pkg::dp_cmd_t               cmd,
	output afgr_pkg::dp_stat_t              stat,
	input  logic                            out_ready,
	output logic                            out_valid,
	output afgr_pkg::out_word_t             out_data
);
	import afgr_pkg::*;

	// configuration
	logic [1:0]          chan_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CAP_W-1:0]    cap_eff;
	logic                mono;

	// stream state
	in_word_t            item_q;
	logic [CNT_W-1:0]    written_q;
	logic [CNT_W-1:0]    consumed_q;
	logic [CNT_W-1:0]    flush_base_q;
	logic [CAP_W-1:0]    fill_q;
	logic [ADDR_W-1:0]   wr_slot_q;
	logic [ADDR_W-1:0]   rd_slot_q;
	logic [GAIN_W-1:0]   applied_q;
	logic [GAIN_W-1:0]   target_q;
	logic                playing_q;
	logic                eos_q;
	logic                in_underrun_q;
	logic [31:0]         underrun_q;

	// pull context
	logic [BLK_W-1:0]    n_q;
	logic [BLK_W-1:0]    avail_q;
	logic [BLK_W-1:0]    k_q;
	logic signed [GNUM_W-1:0]  gnum_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic [PROD_W-1:0]   p_l_q;
	logic [PROD_W-1:0]   p_r_q;
	logic                neg_l_q;
	logic                neg_r_q;

	// output register
	logic                out_valid_q;
	out_word_t           out_q;

	// combinational helpers
	logic [ADDR_W-1:0]   wr_next;
	logic [ADDR_W-1:0]   rd_next;
	logic [BLK_W-1:0]    n_clamp;
	logic [BLK_W-1:0]    avail;
	logic                starved;
	logic [24:0]         g0;
	logic                room;
	logic [FRAME_W-1:0]  wdata;
	logic [FRAME_W-1:0]  rdata;
	logic signed [15:0]  sl;
	logic signed [15:0]  sr;
	logic [16:0]         mag_l;
	logic [16:0]         mag_r;
	logic [40:0]         prod_l;
	logic [40:0]         prod_r;
	logic                div_start;
	logic [DIV_W-1:0]    dvd_l;
	logic [DIV_W-1:0]    dvd_r;
	logic [DIVR_W-1:0]   dvs;
	logic [STEP_W-1:0]   steps;
	logic                done_l;
	logic                done_r;
	logic [DIV_W-1:0]    quo_l;
	logic [DIV_W-1:0]    quo_r;
	logic [DIVR_W-1:0]   rem_l;
	logic [DIVR_W-1:0]   rem_r;
	logic                load;
	out_word_t           res;
	logic [CAP_W-1:0]    fill_after;
	logic                acc;

	// rounding half to even and saturation of one scaled sample
	function automatic logic [15:0] round_sat(
		input logic [QUOT_W-1:0] q,
		input logic [BLK_W-1:0]  rx,
		input logic [15:0]       plo,
		input logic [BLK_W-1:0]  a,
		input logic              neg
	);
		logic [23:0] r2;
		logic [23:0] d;
		logic        inc;
		logic [23:0] q1;
		logic [15:0] y;
		r2  = {rx, plo, 1'b0};
		d   = {a, 16'd0, 1'b0} >> 1;
		inc = (r2 > d) || ((r2 == d) && q[0]);
		q1  = {1'b0, q} + 24'(inc);
		if (neg) begin
			y = (q1 >= 24'd32768) ? 16'h8000 : (~q1[15:0] + 16'd1);
		end else begin
			y = (q1 > 24'd32767) ? 16'h7FFF : q1[15:0];
		end
		return y;
	endfunction

	// effective capacity and slot stepping
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_q > CAP_W'(RING_DEPTH)) begin
			cap_eff = CAP_W'(RING_DEPTH);
		end else begin
			cap_eff = cap_q;
		end
		mono    = chan_q == 2'd1;
		wr_next = ((written_q == '1) || (CAP_W'(wr_slot_q) + CAP_W'(1) == cap_eff))
			? '0 : wr_slot_q + ADDR_W'(1);
		rd_next = ((consumed_q == '1) || (CAP_W'(rd_slot_q) + CAP_W'(1) == cap_eff))
			? '0 : rd_slot_q + ADDR_W'(1);
	end

	// pull setup terms
	always_comb begin
		n_clamp = (item_q.block_frames > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK)
			: item_q.block_frames;
		avail   = (fill_q < CAP_W'(n_clamp)) ? BLK_W'(fill_q) : n_clamp;
		starved = ((consumed_q + CNT_W'(avail) - flush_base_q) != '0) && !eos_q && playing_q;
		g0      = applied_q * avail;
		room    = fill_q < cap_eff;
		wdata   = {mono ? 16'd0 : item_q.right_sample, item_q.left_sample};
	end

	// ring storage
	afgr_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.simple_exec && (item_q.op == OP_WRITE) && room),
		.waddr(wr_slot_q),
		.wdata(wdata),
		.re   (cmd.fr_read),
		.raddr(rd_slot_q),
		.rdata(rdata)
	);

	// magnitude times gain
	always_comb begin
		sl     = rdata[15:0];
		sr     = mono ? 16'sd0 : rdata[31:16];
		mag_l  = sl[15] ? (~{sl[15], sl} + 17'd1) : {1'b0, sl};
		mag_r  = sr[15] ? (~{sr[15], sr} + 17'd1) : {1'b0, sr};
		prod_l = mag_l * gnum_q[23:0];
		prod_r = mag_r * gnum_q[23:0];
	end

	// divider operands: slot recompute or sample scaling
	always_comb begin
		div_start = cmd.rc_start || cmd.fr_div_start;
		if (cmd.rc_start) begin
			dvd_l = written_q;
			dvd_r = consumed_q;
			dvs   = cap_eff;
			steps = STEP_W'(DIV_W);
		end else begin
			dvd_l = {p_l_q[PROD_W-1:16], {(DIV_W-QUOT_W){1'b0}}};
			dvd_r = {p_r_q[PROD_W-1:16], {(DIV_W-QUOT_W){1'b0}}};
			dvs   = DIVR_W'(avail_q);
			steps = STEP_W'(QUOT_W);
		end
	end

	afgr_div u_div_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_l),
		.divisor  (dvs),
		.steps    (steps),
		.done     (done_l),
		.quotient (quo_l),
		.remainder(rem_l)
	);

	afgr_div u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_r),
		.divisor  (dvs),
		.steps    (steps),
		.done     (done_r),
		.quotient (quo_r),
		.remainder(rem_r)
	);

	// result word for the current command
	always_comb begin
		fill_after = fill_q;
		acc        = 1'b1;
		unique case (item_q.op) inside
			OP_WRITE: begin
				acc = room;
				if (room) begin
					fill_after = fill_q + CAP_W'(1);
				end
			end
			OP_FLUSH: fill_after = '0;
			OP_PULL, OP_EOS, OP_PLAY, OP_VOLUME: acc = 1'b1;
			default: acc = 1'b0;
		endcase
		res                = '0;
		res.underrun_total = underrun_q;
		res.accepted       = 1'b1;
		res.last           = (k_q + BLK_W'(1)) == n_q;
		res.fill_level     = fill_q;
		if (cmd.simple_exec) begin
			res.accepted   = acc;
			res.last       = 1'b1;
			res.fill_level = fill_after;
		end else if (cmd.fr_emit) begin
			res.from_ring  = 1'b1;
			res.fill_level = fill_q - CAP_W'(1);
			res.left_out   = round_sat(quo_l[QUOT_W-1:0], rem_l[BLK_W-1:0],
				p_l_q[15:0], avail_q, neg_l_q);
			res.right_out  = round_sat(quo_r[QUOT_W-1:0], rem_r[BLK_W-1:0],
				p_r_q[15:0], avail_q, neg_r_q);
		end
		load = cmd.simple_exec || cmd.fr_emit || cmd.zero_emit;
	end

	// configuration and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q        <= 2'd2;
			cap_q         <= CAP_W'(RING_DEPTH);
			written_q     <= '0;
			consumed_q    <= '0;
			flush_base_q  <= '0;
			fill_q        <= '0;
			wr_slot_q     <= '0;
			rd_slot_q     <= '0;
			applied_q     <= GAIN_W'(65536);
			target_q      <= GAIN_W'(65536);
			playing_q     <= 1'b0;
			eos_q         <= 1'b0;
			in_underrun_q <= 1'b0;
			underrun_q    <= '0;
			k_q           <= '0;
			n_q           <= '0;
			avail_q       <= '0;
		end else begin
			if (cmd.cfg_take) begin
				if (cfg_index == REG_CHANNELS) begin
					chan_q <= cfg_data[1:0];
				end else if (cfg_index == REG_CAPACITY) begin
					cap_q <= cfg_data;
				end
			end
			if (cmd.rc_finish) begin
				wr_slot_q <= rem_l[ADDR_W-1:0];
				rd_slot_q <= rem_r[ADDR_W-1:0];
			end
			if (cmd.simple_exec) begin
				case (item_q.op)
					OP_WRITE: begin
						if (room) begin
							written_q <= written_q + CNT_W'(1);
							wr_slot_q <= wr_next;
							fill_q    <= fill_q + CAP_W'(1);
						end
					end
					OP_FLUSH: begin
						playing_q    <= 1'b0;
						eos_q        <= 1'b0;
						consumed_q   <= written_q;
						flush_base_q <= written_q;
						rd_slot_q    <= wr_slot_q;
						fill_q       <= '0;
					end
					OP_EOS: eos_q <= 1'b1;
					OP_PLAY: playing_q <= item_q.play_flag;
					OP_VOLUME: begin
						target_q <= (item_q.volume > GAIN_W'(GAIN_MAX))
							? GAIN_W'(GAIN_MAX) : item_q.volume;
					end
					default: ;
				endcase
			end
			if (cmd.pull_setup) begin
				n_q     <= n_clamp;
				avail_q <= avail;
				k_q     <= '0;
				if (n_clamp == '0) begin
					in_underrun_q <= 1'b0;
				end else begin
					if (avail != '0) begin
						applied_q <= target_q;
					end
					if (avail < n_clamp) begin
						if (starved && !in_underrun_q) begin
							underrun_q <= underrun_q + 32'd1;
						end
						in_underrun_q <= starved;
					end else begin
						in_underrun_q <= 1'b0;
					end
				end
			end
			if (cmd.fr_emit) begin
				fill_q     <= fill_q - CAP_W'(1);
				consumed_q <= consumed_q + CNT_W'(1);
				rd_slot_q  <= rd_next;
			end
			if (cmd.fr_emit || cmd.zero_emit) begin
				k_q <= k_q + BLK_W'(1);
			end
		end
	end

	// item and ramp arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.item_take) begin
			item_q <= in_data;
		end
		if (cmd.pull_setup) begin
			gnum_q  <= {1'b0, g0};
			delta_q <= {1'b0, target_q} - {1'b0, applied_q};
		end
		if (cmd.fr_read) begin
			gnum_q <= gnum_q + {{(GNUM_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
		end
		if (cmd.fr_mul) begin
			p_l_q   <= prod_l[PROD_W-1:0];
			p_r_q   <= prod_r[PROD_W-1:0];
			neg_l_q <= sl[15];
			neg_r_q <= sr[15];
		end
		if (load) begin
			out_q <= res;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// status to the controller
	always_comb begin
		stat.is_pull    = item_q.op == OP_PULL;
		stat.pull_zero  = n_clamp == '0;
		stat.k_lt_avail = k_q < avail_q;
		stat.last_frame = (k_q + BLK_W'(1)) == n_q;
		stat.div_done   = done_l && done_r;
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

// File: rtl/afgr_ctrl.sv
// controller: sequences configuration, simple ops and pulled frames
`timescale 1ns / 1ps
`default_nettype none
module afgr_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [afgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  afgr_pkg::dp_stat_t             stat,
	output afgr_pkg::dp_cmd_t              cmd
);
	import afgr_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_ready  = !cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_take = 1'b1;
					if (cfg_index == REG_CAPACITY) begin
						state_d = ST_RC_START;
					end
				end else if (in_valid) begin
					cmd.item_take = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_RC_START: begin
				cmd.rc_start = 1'b1;
				state_d      = ST_RC_WAIT;
			end
			ST_RC_WAIT: begin
				if (stat.div_done) begin
					cmd.rc_finish = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EXEC: begin
				if (stat.is_pull) begin
					cmd.pull_setup = 1'b1;
					state_d        = stat.pull_zero ? ST_IDLE : ST_FRAME;
				end else if (stat.out_free) begin
					cmd.simple_exec = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_FRAME: begin
				if (stat.k_lt_avail) begin
					cmd.fr_read = 1'b1;
					state_d     = ST_FR_MUL;
				end else if (stat.out_free) begin
					cmd.zero_emit = 1'b1;
					state_d       = stat.last_frame ? ST_IDLE : ST_FRAME;
				end
			end
			ST_FR_MUL: begin
				cmd.fr_mul = 1'b1;
				state_d    = ST_FR_DIV_START;
			end
			ST_FR_DIV_START: begin
				cmd.fr_div_start = 1'b1;
				state_d          = ST_FR_DIV_WAIT;
			end
			ST_FR_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_FR_EMIT;
				end
			end
			ST_FR_EMIT: begin
				if (stat.out_free) begin
					cmd.fr_emit = 1'b1;
					state_d     = stat.last_frame ? ST_IDLE : ST_FRAME;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/audio_output_fifo_gain_ramp_unit.sv
// Audio frame fifo with linear gain ramp: a non-pull word gives its result once the output
// register is free. A pull emits one result per frame: a ring frame takes ram read, gain
// multiply, 23-step serial divide and rounding, a zero-fill frame none. A capacity write
// recomputes the ring slots with the 40-step serial divider. Reset clears counters and
// flags and sets gains to unity at once; ring contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module audio_output_fifo_gain_ramp_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  afgr_pkg::in_word_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output afgr_pkg::out_word_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [afgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [afgr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import afgr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	afgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.stat     (stat),
		.cmd      (cmd)
	);

	// ring and arithmetic
	afgr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data)
	);
endmodule
`default_nettype wire

// File: rtl/afgr_chk.sv
// port level checker for the audio output fifo, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module afgr_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input afgr_pkg::out_word_t             out_data,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);
	import afgr_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// silent and non-pull words carry zero samples
	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.from_ring |-> out_data.left_out == 16'sd0
			&& out_data.right_out == 16'sd0)
		else $error("non-ring word with nonzero samples");

	// fill never exceeds the ring
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.fill_level <= 11'(RING_DEPTH))
		else $error("fill level beyond ring depth");

	// a refused word is a single result
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.accepted |-> out_data.last && !out_data.from_ring)
		else $error("refused word not a lone result");

	// configuration and items are never taken together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && cfg_valid && cfg_ready))
		else $error("configuration and item taken in one cycle");
endmodule

bind audio_output_fifo_gain_ramp_unit afgr_chk u_afgr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
`default_nettype wire

// File: bench/tb_audio_output_fifo_gain_ramp_unit.sv
// testbench for the audio output fifo with gain ramp: directed table, random traffic, self check
`timescale 1ns / 1ps
module tb_audio_output_fifo_gain_ramp_unit;
	import afgr_pkg::*;

	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;
	localparam int UNITY_GAIN = 65536;
	localparam int IDLE_WAIT  = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	audio_output_fifo_gain_ramp_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [31:0] ring_mirror [RING_DEPTH];
	logic [39:0] wr_count, rd_count, flush_mark;
	logic [17:0] gain_now, gain_goal;
	logic        is_playing, stream_ended, starving;
	logic [31:0] underruns;
	logic [1:0]  chan_reg;
	logic [10:0] cap_reg;
	out_word_t   due_words[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int frames_ring = 0;

	function automatic longint unsigned ring_size();
		longint unsigned c;
		c = cap_reg;
		if (c == 0) c = 1;
		if (c > RING_DEPTH) c = RING_DEPTH;
		return c;
	endfunction

	// sample * gnum / (n * 65536), round half to even, clip to 16 bits
	function automatic logic signed [15:0] apply_gain(logic signed [15:0] s,
			longint unsigned gnum, longint unsigned n);
		longint unsigned mag, p, d, q, r;
		mag = (s < 0) ? longint'(-int'(s)) : longint'(s);
		p = mag * gnum;
		d = n << 16;
		q = p / d;
		r = p % d;
		if (2 * r > d || (2 * r == d && q[0])) q++;
		if (s < 0) return (q >= 32768) ? -16'sd32768 : -$signed(q[15:0]);
		return (q > 32767) ? 16'sd32767 : $signed(q[15:0]);
	endfunction

	// work out the result words of one accepted input word
	task automatic predict_word(in_word_t w);
		out_word_t res[$];
		out_word_t o;
		longint unsigned n, fill, avail, cap, kk, gnum, cnt;
		logic [31:0] fw;
		logic ramp, starved, mono;
		mono = (chan_reg == 2'd1);
		cap = ring_size();
		fill = 40'(wr_count - rd_count);
		if (w.op == OP_PULL) begin
			n = w.block_frames;
			if (n > MAX_BLOCK) n = MAX_BLOCK;
			if (n == 0) begin
				starving = 1'b0;
				return;
			end
			ramp = !(gain_now == UNITY_GAIN && gain_goal == UNITY_GAIN);
			avail = (fill < n) ? fill : n;
			for (longint unsigned k = 0; k < n; k++) begin
				o = '0;
				o.accepted = 1'b1;
				if (k < avail) begin
					cnt = 40'(rd_count + k);
					fw = ring_mirror[cnt % cap];
					o.left_out = fw[15:0];
					o.right_out = mono ? 16'sd0 : $signed(fw[31:16]);
					if (ramp) begin
						kk = k + 1;
						gnum = gain_now * (avail - kk) + gain_goal * kk;
						o.left_out = apply_gain(o.left_out, gnum, avail);
						o.right_out = apply_gain(o.right_out, gnum, avail);
					end
					o.from_ring = 1'b1;
					fill--;
					frames_ring++;
				end
				o.last = (k + 1 == n);
				o.fill_level = fill[10:0];
				res.push_back(o);
			end
			if (avail > 0) begin
				if (ramp) gain_now = gain_goal;
				rd_count = 40'(rd_count + avail);
			end
			if (avail < n) begin
				starved = (40'(rd_count - flush_mark) != 0) && !stream_ended && is_playing;
				if (starved && !starving) underruns++;
				starving = starved;
			end else begin
				starving = 1'b0;
			end
		end else begin
			o = '0;
			o.accepted = 1'b1;
			case (w.op)
				OP_WRITE: begin
					if (fill < cap) begin
						ring_mirror[wr_count % cap] = mono ? {16'h0, w.left_sample} :
							{w.right_sample, w.left_sample};
						wr_count = 40'(wr_count + 1);
					end else begin
						o.accepted = 1'b0;
					end
				end
				OP_FLUSH: begin
					is_playing = 1'b0;
					rd_count = wr_count;
					flush_mark = wr_count;
					stream_ended = 1'b0;
				end
				OP_EOS: stream_ended = 1'b1;
				OP_PLAY: is_playing = w.play_flag;
				OP_VOLUME: gain_goal = (w.volume > GAIN_MAX) ? 18'(GAIN_MAX) : w.volume;
				default: o.accepted = 1'b0;
			endcase
			o.last = 1'b1;
			o.fill_level = 11'(40'(wr_count - rd_count));
			res.push_back(o);
		end
		foreach (res[i]) begin
			res[i].underrun_total = underruns;
			due_words.push_back(res[i]);
		end
	endtask

	// drive one input word, hold until taken
	task automatic send_word(in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		predict_word(w);
		words_in++;
	endtask

	// register write, only once the block has gone quiet
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_CHANNELS) chan_reg = val[1:0];
		else cap_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_word_t mk(logic [2:0] op, logic [15:0] l, logic [15:0] r,
			logic [6:0] blk, logic pf, logic [17:0] vol);
		in_word_t w;
		w.op = op;
		w.left_sample = l;
		w.right_sample = r;
		w.block_frames = blk;
		w.play_flag = pf;
		w.volume = vol;
		return w;
	endfunction

	function automatic out_word_t simple_res(logic acc, logic [31:0] ur, logic [10:0] fl);
		out_word_t o;
		o = '0;
		o.accepted = acc;
		o.last = 1'b1;
		o.underrun_total = ur;
		o.fill_level = fl;
		return o;
	endfunction

	// random word, mostly writes and pulls so the ring fills and drains
	function automatic in_word_t random_word();
		int sel;
		logic [17:0] vol;
		logic [6:0] blk;
		sel = $urandom_range(99);
		blk = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(8));
		case ($urandom_range(3))
			0: vol = 18'(UNITY_GAIN);
			1: vol = 18'($urandom_range(GAIN_MAX));
			2: vol = 18'($urandom);
			default: vol = 18'(UNITY_GAIN + $urandom_range(4096) - 2048);
		endcase
		if (sel < 45) return mk(OP_WRITE, 16'($urandom), 16'($urandom), 7'($urandom), 1'($urandom),
			18'($urandom));
		if (sel < 72) return mk(OP_PULL, 16'($urandom), 16'($urandom), blk, 1'($urandom), 0);
		if (sel < 76) return mk(OP_FLUSH, 0, 0, 0, 0, 0);
		if (sel < 80) return mk(OP_EOS, 0, 0, 0, 0, 0);
		if (sel < 88) return mk(OP_PLAY, 0, 0, 0, ($urandom_range(3) != 0), 0);
		if (sel < 97) return mk(OP_VOLUME, 0, 0, 0, 0, vol);
		return mk(($urandom_range(1) != 0) ? OP_BAD6 : OP_BAD7, 16'($urandom), 0, 0, 0, 0);
	endfunction

	task automatic field_check(string fname, longint unsigned e, longint unsigned a);
		if (e != a) begin
			errors++;
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, fname, e, a);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			words_out++;
			if (due_words.size() == 0) begin
				errors++;
				$display("%0t unexpected result word %h", $time, out_data);
			end else begin
				e = due_words.pop_front();
				field_check("left_out", 16'(e.left_out), 16'(out_data.left_out));
				field_check("right_out", 16'(e.right_out), 16'(out_data.right_out));
				field_check("from_ring", e.from_ring, out_data.from_ring);
				field_check("accepted", e.accepted, out_data.accepted);
				field_check("last", e.last, out_data.last);
				field_check("underrun_total", e.underrun_total, out_data.underrun_total);
				field_check("fill_level", e.fill_level, out_data.fill_level);
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// directed table
	typedef struct {
		logic        is_cfg;
		logic [1:0]  idx;
		logic [10:0] val;
		in_word_t    w;
		logic        typed;
		out_word_t   res;
	} row_t;

	row_t plan[$];

	task automatic add_item(in_word_t w);
		row_t r;
		r = '{is_cfg: 1'b0, idx: '0, val: '0, w: w, typed: 1'b0, res: '0};
		plan.push_back(r);
	endtask

	task automatic add_typed(in_word_t w, out_word_t o);
		row_t r;
		r = '{is_cfg: 1'b0, idx: '0, val: '0, w: w, typed: 1'b1, res: o};
		plan.push_back(r);
	endtask

	task automatic add_cfg(logic [1:0] idx, logic [10:0] val);
		row_t r;
		r = '{is_cfg: 1'b1, idx: idx, val: val, w: '0, typed: 1'b0, res: '0};
		plan.push_back(r);
	endtask

	// stimulus
	initial begin
		int phase_idle[4];
		int phase_stall[4];
		logic [1:0] phase_chan[4];
		logic [10:0] phase_cap[4];
		phase_idle = '{0, 86, 0, 34};
		phase_stall = '{0, 0, 86, 34};
		phase_chan = '{2'd1, 2'd0, 2'd3, 2'd2};
		phase_cap = '{11'd1, 11'd2047, 11'd3, 11'd17};
		wr_count = '0;
		rd_count = '0;
		flush_mark = '0;
		gain_now = 18'(UNITY_GAIN);
		gain_goal = 18'(UNITY_GAIN);
		is_playing = 1'b0;
		stream_ended = 1'b0;
		starving = 1'b0;
		underruns = '0;
		chan_reg = 2'd2;
		cap_reg = 11'd1024;

		// undefined ops, empty pull, extremes of samples
		add_typed(mk(OP_BAD6, 0, 0, 0, 0, 0), simple_res(0, 0, 0));
		add_typed(mk(OP_BAD7, 0, 0, 0, 0, 0), simple_res(0, 0, 0));
		add_item(mk(OP_PULL, 0, 0, 7'd3, 0, 0));
		add_typed(mk(OP_WRITE, 16'h7fff, 16'h8000, 0, 0, 0), simple_res(1, 0, 1));
		add_typed(mk(OP_WRITE, 16'h8000, 16'h7fff, 0, 0, 0), simple_res(1, 0, 2));
		add_typed(mk(OP_WRITE, 16'h0000, 16'hffff, 0, 0, 0), simple_res(1, 0, 3));
		add_item(mk(OP_WRITE, 16'h0001, 16'hfffe, 0, 0, 0));
		add_item(mk(OP_WRITE, 16'h4000, 16'hc000, 0, 0, 0));
		add_item(mk(OP_WRITE, 16'h0003, 16'hfffd, 0, 0, 0));
		add_item(mk(OP_WRITE, 16'h1234, 16'hedcb, 0, 0, 0));
		add_item(mk(OP_WRITE, 16'h5555, 16'haaaa, 0, 0, 0));
		// capacity shrunk below fill: writes refused, pulls drain
		add_cfg(REG_CAPACITY, 11'd4);
		add_typed(mk(OP_WRITE, 16'h1111, 16'h2222, 0, 0, 0), simple_res(0, 0, 8));
		add_typed(mk(OP_VOLUME, 0, 0, 0, 0, 18'd131072), simple_res(1, 0, 8));
		add_item(mk(OP_PULL, 0, 0, 7'd3, 0, 0));
		add_item(mk(OP_VOLUME, 0, 0, 0, 0, 18'd0));
		add_item(mk(OP_PULL, 0, 0, 7'd2, 0, 0));
		add_item(mk(OP_VOLUME, 0, 0, 0, 0, 18'h3ffff));
		add_item(mk(OP_PLAY, 0, 0, 0, 1, 0));
		// starvation while playing, repeat, zero-length and oversized pulls
		add_item(mk(OP_PULL, 0, 0, 7'd10, 0, 0));
		add_item(mk(OP_PULL, 0, 0, 7'd2, 0, 0));
		add_item(mk(OP_PULL, 0, 0, 7'd0, 0, 0));
		add_item(mk(OP_PULL, 0, 0, 7'd127, 0, 0));
		add_item(mk(OP_EOS, 0, 0, 0, 0, 0));
		add_item(mk(OP_PULL, 0, 0, 7'd1, 0, 0));
		add_typed(mk(OP_FLUSH, 0, 0, 0, 0, 0), simple_res(1, 2, 0));
		add_item(mk(OP_VOLUME, 0, 0, 0, 0, 18'(UNITY_GAIN)));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_word(plan[i].w);
				if (plan[i].typed) begin
					void'(due_words.pop_back());
					due_words.push_back(plan[i].res);
				end
			end
		end

		// random phases, each under its own setting
		for (int p = 0; p < 4; p++) begin
			send_word(mk(OP_FLUSH, 0, 0, 0, 0, 0));
			write_reg(REG_CHANNELS, phase_chan[p]);
			write_reg(REG_CAPACITY, phase_cap[p]);
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			send_word(mk(OP_PLAY, 0, 0, 0, 1, 0));
			for (int i = 0; i < 19; i++) send_word(random_word());
		end
		send_word(mk(OP_PULL, 0, 0, 7'd64, 0, 0));
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
		$display("sent %0d words, checked %0d results, %0d ring frames through the gain path",
			words_in, words_out, frames_ring);
		$display("covered mono and stereo, capacities 1 to 1024 with out-of-range values, ramps");
		if (errors == 0 && due_words.size() == 0)
			$display("tb_audio_output_fifo_gain_ramp_unit: clean");
		else
			$display("tb_audio_output_fifo_gain_ramp_unit: errors");
		$finish;
	end

	// watchdog
	initial begin
		#80_000_000;
		$display("timeout with %0d results outstanding", due_words.size());
		$display("tb_audio_output_fifo_gain_ramp_unit: errors");
		$finish;
	end

endmodule
